[src/xcr_pkg.sv]
// Shared types, character codes and helpers for the character reference decoder.
package xcr_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int CP_WIDTH        = 32;

  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_X_LOWER = 8'h78;
  localparam logic [7:0] CH_X_UPPER = 8'h58;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  // Digit value of 16 marks a byte that is no hex digit.
  localparam logic [4:0] NO_DIGIT = 5'd16;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_AMP    = 2'd1,
    MODE_BODY   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    PH_WS     = 3'd0,
    PH_SIGN   = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_STOP   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_OCT = 2'd1,
    BASE_HEX = 2'd2
  } base_t;

  typedef struct packed {
    logic [CP_WIDTH-1:0] code_point;
    logic                last;
  } result_t;

  // Results produced by one accepted request: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] d;
    d = NO_DIGIT;
    if (b >= 8'h30 && b <= 8'h39) begin
      d = 5'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d = 5'(b - 8'h61 + 8'd10);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d = 5'(b - 8'h41 + 8'd10);
    end
    return d;
  endfunction

  function automatic logic [4:0] radix_of(input base_t base);
    logic [4:0] r;
    unique case (base)
      BASE_HEX: r = 5'd16;
      BASE_OCT: r = 5'd8;
      default:  r = 5'd10;
    endcase
    return r;
  endfunction

endpackage

[src/xcr_scanner.sv]
// Reference scanner: mode and number-scan state, updated once per accepted request.
module xcr_scanner #(
  parameter int VALUE_WIDTH = xcr_pkg::VALUE_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  output xcr_pkg::push_t  push
);
  import xcr_pkg::*;

  mode_t                  mode, mode_next;
  logic                   hex_mode, hex_mode_next;
  logic                   body_nonempty, body_nonempty_next;
  phase_t                 scan_phase, scan_phase_next;
  base_t                  scan_base, scan_base_next;
  logic                   is_negative, is_negative_next;
  logic                   digit_seen, digit_seen_next;
  logic [VALUE_WIDTH-1:0] accumulator, accumulator_next;

  logic [4:0]             digit;
  base_t                  take_base;
  logic                   take_ok;
  logic [VALUE_WIDTH-1:0] acc_step;
  logic [VALUE_WIDTH-1:0] neg_value;
  logic                   is_space;

  assign digit    = hex_digit(in_byte);
  assign is_space = (in_byte == CH_SPACE) || (in_byte >= CH_TAB && in_byte <= CH_CR);

  // After a leading zero the base is settled by the byte that follows it.
  assign take_base = (scan_phase == PH_ZERO) ? (hex_mode ? BASE_HEX : BASE_OCT) : scan_base;
  assign take_ok   = digit < radix_of(take_base);

  always_comb begin
    logic [VALUE_WIDTH-1:0] scaled;
    unique case (take_base)
      BASE_HEX: scaled = accumulator << 4;
      BASE_OCT: scaled = accumulator << 3;
      default:  scaled = (accumulator << 3) + (accumulator << 1);
    endcase
    acc_step = scaled + VALUE_WIDTH'(digit);
  end

  assign neg_value = is_negative ? (~accumulator + 1'b1) : accumulator;

  // Next state.
  always_comb begin
    logic run_sign;
    run_sign           = 1'b0;
    mode_next          = mode;
    hex_mode_next      = hex_mode;
    body_nonempty_next = body_nonempty;
    scan_phase_next    = scan_phase;
    scan_base_next     = scan_base;
    is_negative_next   = is_negative;
    digit_seen_next    = digit_seen;
    accumulator_next   = accumulator;

    unique case (mode)
      MODE_AMP: begin
        mode_next = (in_byte == CH_HASH) ? MODE_BODY : MODE_NORMAL;
      end
      MODE_BODY: begin
        if (in_byte == CH_X_LOWER && !body_nonempty) begin
          hex_mode_next = 1'b1;
        end else if (in_byte == CH_SEMI) begin
          mode_next          = MODE_NORMAL;
          hex_mode_next      = 1'b0;
          body_nonempty_next = 1'b0;
          scan_phase_next    = PH_WS;
          scan_base_next     = BASE_DEC;
          is_negative_next   = 1'b0;
          digit_seen_next    = 1'b0;
          accumulator_next   = '0;
        end else begin
          body_nonempty_next = 1'b1;
          unique case (scan_phase)
            PH_WS: begin
              if (!is_space) begin
                scan_phase_next = PH_SIGN;
                if (in_byte == CH_PLUS || in_byte == CH_MINUS) begin
                  is_negative_next = (in_byte == CH_MINUS);
                end else begin
                  run_sign = 1'b1;
                end
              end
            end
            PH_SIGN: run_sign = 1'b1;
            PH_ZERO: begin
              scan_phase_next = PH_DIGITS;
              if (in_byte == CH_X_LOWER || in_byte == CH_X_UPPER) begin
                scan_base_next = BASE_HEX;
              end else begin
                scan_base_next = take_base;
                if (take_ok) begin
                  accumulator_next = acc_step;
                  digit_seen_next  = 1'b1;
                end else begin
                  scan_phase_next = PH_STOP;
                end
              end
            end
            PH_DIGITS: begin
              if (take_ok) begin
                accumulator_next = acc_step;
                digit_seen_next  = 1'b1;
              end else begin
                scan_phase_next = PH_STOP;
              end
            end
            default: ;
          endcase
          // First byte after whitespace and sign picks zero, hex or decimal.
          if (run_sign) begin
            if (in_byte == CH_ZERO) begin
              digit_seen_next  = 1'b1;
              accumulator_next = '0;
              scan_phase_next  = PH_ZERO;
            end else if (hex_mode && digit < NO_DIGIT) begin
              scan_base_next   = BASE_HEX;
              accumulator_next = VALUE_WIDTH'(digit);
              digit_seen_next  = 1'b1;
              scan_phase_next  = PH_DIGITS;
            end else if (!hex_mode && digit >= 5'd1 && digit <= 5'd9) begin
              scan_base_next   = BASE_DEC;
              accumulator_next = VALUE_WIDTH'(digit);
              digit_seen_next  = 1'b1;
              scan_phase_next  = PH_DIGITS;
            end else begin
              scan_phase_next = PH_STOP;
            end
          end
        end
      end
      default: begin
        if (in_byte == CH_AMP) begin
          mode_next          = MODE_AMP;
          hex_mode_next      = 1'b0;
          body_nonempty_next = 1'b0;
          scan_phase_next    = PH_WS;
          scan_base_next     = BASE_DEC;
          is_negative_next   = 1'b0;
          digit_seen_next    = 1'b0;
          accumulator_next   = '0;
        end else begin
          mode_next = MODE_NORMAL;
        end
      end
    endcase
  end

  // Results.
  always_comb begin
    push = '0;
    unique case (mode)
      MODE_AMP: begin
        if (in_byte != CH_HASH) begin
          push.count             = 2'd2;
          push.first.code_point  = CP_WIDTH'(CH_AMP);
          push.first.last        = 1'b0;
          push.second.code_point = CP_WIDTH'(in_byte);
          push.second.last       = 1'b1;
        end
      end
      MODE_BODY: begin
        if (in_byte == CH_SEMI && !(in_byte == CH_X_LOWER && !body_nonempty) && digit_seen) begin
          push.count            = 2'd1;
          push.first.code_point = CP_WIDTH'(neg_value);
          push.first.last       = 1'b1;
        end
      end
      default: begin
        if (in_byte != CH_AMP) begin
          push.count            = 2'd1;
          push.first.code_point = CP_WIDTH'(in_byte);
          push.first.last       = 1'b1;
        end
      end
    endcase
    if (!accept) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_NORMAL;
      hex_mode      <= 1'b0;
      body_nonempty <= 1'b0;
      scan_phase    <= PH_WS;
      scan_base     <= BASE_DEC;
      is_negative   <= 1'b0;
      digit_seen    <= 1'b0;
      accumulator   <= '0;
    end else if (accept) begin
      mode          <= mode_next;
      hex_mode      <= hex_mode_next;
      body_nonempty <= body_nonempty_next;
      scan_phase    <= scan_phase_next;
      scan_base     <= scan_base_next;
      is_negative   <= is_negative_next;
      digit_seen    <= digit_seen_next;
      accumulator   <= accumulator_next;
    end
  end

endmodule

[src/xcr_out_queue.sv]
// Three-entry result queue that takes up to two results per cycle and gives one.
module xcr_out_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  xcr_pkg::push_t                push,
  output logic                          room,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [xcr_pkg::CP_WIDTH-1:0]  code_point,
  output logic                          last
);
  import xcr_pkg::*;

  localparam int DEPTH = 3;

  result_t    entries [DEPTH];
  logic [1:0] rd_ptr, wr_ptr, wr_ptr_next;
  logic [1:0] count, count_next;
  logic       pop;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    return (p == 2'(DEPTH - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  assign out_valid  = (count != 2'd0);
  assign pop        = out_valid && out_ready;
  assign room       = (count <= 2'd1);
  assign code_point = entries[rd_ptr].code_point;
  assign last       = entries[rd_ptr].last;

  assign count_next  = count + push.count - {1'b0, pop};
  assign wr_ptr_next = (push.count == 2'd2) ? ptr_inc(ptr_inc(wr_ptr)) :
                       (push.count == 2'd1) ? ptr_inc(wr_ptr) : wr_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      count  <= count_next;
      wr_ptr <= wr_ptr_next;
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[ptr_inc(wr_ptr)] <= push.second;
    end
  end

endmodule

[src/xml_char_ref_decoder.sv]
// Top level of the XML numeric character reference decoder.
//
// The decoder takes one text byte per request and returns code points. Plain
// bytes pass through; "&#...;" is scanned as a decimal, octal (leading 0) or
// hexadecimal ("&#x" or a 0x prefix) number with optional leading whitespace
// and sign, and the value is returned, in two's complement when negative, if
// the body held at least one digit. An ampersand not followed by '#' returns
// the ampersand and then the byte itself, the second marked by last. A byte
// is taken in every cycle as long as the three-entry result queue has room for
// two results: with out_ready held high the block runs at one byte per clock,
// and a lone ampersand stalls the input while its two results drain. The
// scan state updates in the same cycle the byte is accepted; a result is
// queued and reaches the outputs after earlier results. The VALUE_WIDTH-bit
// accumulator wraps; the returned value keeps its low 32 bits.
module xml_char_ref_decoder #(
  parameter int VALUE_WIDTH = xcr_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [xcr_pkg::CP_WIDTH-1:0]  code_point,
  output logic                          last
);
  import xcr_pkg::*;

  push_t push;
  logic  accept;

  // A request is taken only when the queue can hold the worst case of two results.
  assign accept = in_valid && in_ready;

  xcr_scanner #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_scanner (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .push    (push)
  );

  xcr_out_queue u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_point (code_point),
    .last       (last)
  );

endmodule
